[sv/mmc3om_pkg.sv]
// Shared types and constants for the MMC3 outer-bank mapper.
// Used by the front, back and top-level modules.
`timescale 1ns / 1ps

package mmc3om_pkg;

	// input command codes
	localparam logic [1:0] CMD_REG_WRITE   = 2'd0;
	localparam logic [1:0] CMD_OUTER_WRITE = 2'd1;
	localparam logic [1:0] CMD_SCANLINE    = 2'd2;

	// register decode: address AND E001h
	localparam logic [15:0] ADDR_DECODE_MASK = 16'hE001;
	localparam logic [15:0] REG_BANK_SELECT  = 16'h8000;
	localparam logic [15:0] REG_BANK_DATA    = 16'h8001;
	localparam logic [15:0] REG_MIRROR       = 16'hA000;
	localparam logic [15:0] REG_RAM_ENABLE   = 16'hA001;
	localparam logic [15:0] REG_IRQ_PRESET   = 16'hC000;
	localparam logic [15:0] REG_IRQ_REARM    = 16'hC001;
	localparam logic [15:0] REG_IRQ_DISABLE  = 16'hE000;
	localparam logic [15:0] REG_IRQ_ENABLE   = 16'hE001;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_ROM_PRESENT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUAD_NT         = 2'd2;

	localparam logic [8:0] PRG_BANK_COUNT_RESET = 9'd32;

	localparam int QUEUE_DEPTH_DEFAULT = 2;

	typedef enum logic [1:0] {
		JOB_SLOTS,
		JOB_MIRROR,
		JOB_IRQ_RAISE,
		JOB_IRQ_CLEAR
	} job_kind_t;

	// one queued job: a snapshot of what the back end needs to emit its results
	typedef struct packed {
		job_kind_t        kind;
		logic             mirror_h;
		logic             prg_swap;   // bank select bit 6
		logic             chr_invert; // bank select bit 7
		logic [2:0]       outer;
		logic [7:0][7:0]  banks;
	} job_t;

endpackage

[sv/mmc3om_front.sv]
// Front end: accepts input items, updates the mapper register state and
// the IRQ counter, and queues a job for every item that gives results. Uses mmc3om_pkg.
`timescale 1ns / 1ps

module mmc3om_front
	import mmc3om_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	input  logic        rendering_on,
	input  logic        quad_nt,
	input  logic        q_full,
	output logic        q_push,
	output job_t        q_job
);

	logic [7:0]      bank_select_q, bank_select_d;
	logic [7:0][7:0] banks_q, banks_d;
	logic            mirror_q, mirror_d;
	logic            ram_enable_q, ram_enable_d;
	logic [2:0]      outer_q, outer_d;
	logic [7:0]      irq_preset_q, irq_preset_d;
	logic [7:0]      irq_count_q, irq_count_d;
	logic            irq_rearm_q, irq_rearm_d;
	logic            irq_enable_q, irq_enable_d;
	logic            has_job;
	job_kind_t       kind;
	logic [15:0]     reg_sel;
	logic            accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign reg_sel  = address & ADDR_DECODE_MASK;

	always_comb begin
		bank_select_d = bank_select_q;
		banks_d       = banks_q;
		mirror_d      = mirror_q;
		ram_enable_d  = ram_enable_q;
		outer_d       = outer_q;
		irq_preset_d  = irq_preset_q;
		irq_count_d   = irq_count_q;
		irq_rearm_d   = irq_rearm_q;
		irq_enable_d  = irq_enable_q;
		has_job       = 1'b0;
		kind          = JOB_SLOTS;
		case (cmd)
			CMD_REG_WRITE: begin
				unique case (reg_sel)
					REG_BANK_SELECT: begin
						bank_select_d = data;
						has_job       = 1'b1;
					end
					REG_BANK_DATA: begin
						banks_d[bank_select_q[2:0]] = data;
						has_job                     = 1'b1;
					end
					REG_MIRROR: begin
						mirror_d = data[0];
						has_job  = !quad_nt;
						kind     = JOB_MIRROR;
					end
					REG_RAM_ENABLE:  ram_enable_d = data[7];
					REG_IRQ_PRESET:  irq_preset_d = data;
					REG_IRQ_REARM:   irq_rearm_d  = 1'b1;
					REG_IRQ_DISABLE: begin
						irq_enable_d = 1'b0;
						has_job      = 1'b1;
						kind         = JOB_IRQ_CLEAR;
					end
					REG_IRQ_ENABLE:  irq_enable_d = 1'b1;
					default: ;
				endcase
			end
			CMD_OUTER_WRITE: begin
				if (ram_enable_q) begin
					outer_d = data[2:0];
					has_job = 1'b1;
				end
			end
			CMD_SCANLINE: begin
				if (rendering_on) begin
					if (irq_count_q == 8'd0 || irq_rearm_q) begin
						irq_count_d = irq_preset_q;
						irq_rearm_d = 1'b0;
					end else begin
						irq_count_d = irq_count_q - 8'd1;
					end
					has_job = (irq_count_d == 8'd0) && irq_enable_q;
					kind    = JOB_IRQ_RAISE;
				end
			end
			default: ;
		endcase
	end

	assign q_push           = accept && has_job;
	assign q_job.kind       = kind;
	assign q_job.mirror_h   = mirror_d;
	assign q_job.prg_swap   = bank_select_d[6];
	assign q_job.chr_invert = bank_select_d[7];
	assign q_job.outer      = outer_d;
	assign q_job.banks      = banks_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= '0;
			banks_q       <= {8'd1, {7{8'd0}}};
			mirror_q      <= 1'b0;
			ram_enable_q  <= 1'b0;
			outer_q       <= '0;
			irq_preset_q  <= '0;
			irq_count_q   <= '0;
			irq_rearm_q   <= 1'b0;
			irq_enable_q  <= 1'b0;
		end else if (accept) begin
			bank_select_q <= bank_select_d;
			banks_q       <= banks_d;
			mirror_q      <= mirror_d;
			ram_enable_q  <= ram_enable_d;
			outer_q       <= outer_d;
			irq_preset_q  <= irq_preset_d;
			irq_count_q   <= irq_count_d;
			irq_rearm_q   <= irq_rearm_d;
			irq_enable_q  <= irq_enable_d;
		end
	end

endmodule

[sv/mmc3om_fifo.sv]
// Small register FIFO that decouples the front end from the back end.
// Generic in width and depth; no package dependencies.
`timescale 1ns / 1ps

module mmc3om_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             not_empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == CNT_W'(DEPTH);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue read while empty");
`endif

endmodule

[sv/mmc3om_back.sv]
// Back end: takes jobs from the queue and emits their results one per cycle
// through an output register while out_ready does not stall it. Uses mmc3om_pkg.
`timescale 1ns / 1ps

module mmc3om_back
	import mmc3om_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [8:0] prg_bank_count,
	input  logic       chr_rom_present,
	input  job_t       q_head,
	input  logic       q_not_empty,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       slot_valid,
	output logic       slot_is_chr,
	output logic [2:0] slot_number,
	output logic [7:0] bank_number,
	output logic       mirror_update,
	output logic       mirror_horizontal,
	output logic       irq_raise,
	output logic       irq_clear,
	output logic       last
);

	typedef struct packed {
		logic       slot_valid;
		logic       slot_is_chr;
		logic [2:0] slot_number;
		logic [7:0] bank_number;
		logic       mirror_update;
		logic       mirror_horizontal;
		logic       irq_raise;
		logic       irq_clear;
		logic       last;
	} result_t;

	job_t       cur_q;
	logic       cur_valid_q;
	logic [3:0] idx_q;
	result_t    res, out_q;
	logic       out_valid_q;
	logic       emit;

	logic [8:0] prg_last_w, prg_slast_w;
	logic [7:0] prg_inner, prg_or_bits, prg_and_bits, chr_inner;
	logic [2:0] chr_idx;

	assign prg_last_w   = prg_bank_count - 9'd1;
	assign prg_slast_w  = prg_bank_count - 9'd2;
	assign prg_or_bits  = {3'b000, cur_q.outer[2], &cur_q.outer[1:0], 3'b000};
	assign prg_and_bits = {4'b0000, cur_q.outer[2], 3'b111};
	assign chr_idx      = 3'(idx_q - 4'd4);

	always_comb begin
		case (idx_q[1:0])
			2'd0:    prg_inner = cur_q.prg_swap ? prg_slast_w[7:0] : cur_q.banks[6];
			2'd1:    prg_inner = cur_q.banks[7];
			2'd2:    prg_inner = cur_q.prg_swap ? cur_q.banks[6] : prg_slast_w[7:0];
			default: prg_inner = prg_last_w[7:0];
		endcase
	end

	// the two 2 KiB banks land in the half picked by bank select bit 7
	always_comb begin
		if (chr_idx[2] == cur_q.chr_invert) begin
			case (chr_idx[1:0])
				2'd0:    chr_inner = {cur_q.banks[0][7:1], 1'b0};
				2'd1:    chr_inner = {cur_q.banks[0][7:1], 1'b1};
				2'd2:    chr_inner = {cur_q.banks[1][7:1], 1'b0};
				default: chr_inner = {cur_q.banks[1][7:1], 1'b1};
			endcase
		end else begin
			chr_inner = cur_q.banks[{1'b0, chr_idx[1:0]} + 3'd2];
		end
	end

	always_comb begin
		res = '0;
		unique case (cur_q.kind)
			JOB_SLOTS: begin
				res.slot_valid = 1'b1;
				if (idx_q < 4'd4) begin
					res.slot_number = {1'b0, idx_q[1:0]};
					res.bank_number = prg_or_bits | (prg_inner & prg_and_bits);
					res.last        = !chr_rom_present && idx_q == 4'd3;
				end else begin
					res.slot_is_chr = 1'b1;
					res.slot_number = chr_idx;
					res.bank_number = {chr_inner[7] | cur_q.outer[2], chr_inner[6:0]};
					res.last        = chr_idx == 3'd7;
				end
			end
			JOB_MIRROR: begin
				res.mirror_update     = 1'b1;
				res.mirror_horizontal = cur_q.mirror_h;
				res.last              = 1'b1;
			end
			JOB_IRQ_RAISE: begin
				res.irq_raise = 1'b1;
				res.last      = 1'b1;
			end
			JOB_IRQ_CLEAR: begin
				res.irq_clear = 1'b1;
				res.last      = 1'b1;
			end
			default: ;
		endcase
	end

	assign emit  = cur_valid_q && (!out_valid_q || out_ready);
	assign q_pop = q_not_empty && (!cur_valid_q || (emit && res.last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop)
				cur_valid_q <= 1'b1;
			else if (emit && res.last)
				cur_valid_q <= 1'b0;
			if (emit) begin
				idx_q       <= res.last ? 4'd0 : idx_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_head;
		if (emit)
			out_q <= res;
	end

	assign out_valid         = out_valid_q;
	assign slot_valid        = out_q.slot_valid;
	assign slot_is_chr       = out_q.slot_is_chr;
	assign slot_number       = out_q.slot_number;
	assign bank_number       = out_q.bank_number;
	assign mirror_update     = out_q.mirror_update;
	assign mirror_horizontal = out_q.mirror_horizontal;
	assign irq_raise         = out_q.irq_raise;
	assign irq_clear         = out_q.irq_clear;
	assign last              = out_q.last;

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> idx_q <= 4'd11) else $error("slot index past the last slot");
	a_single_result_jobs: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && cur_q.kind != JOB_SLOTS |-> idx_q == 4'd0)
		else $error("single-result job advanced its index");
`endif

endmodule

[sv/mmc3_outer_bank_mapper_unit.sv]
// MMC3-style bank mapper with a 3-bit outer bank register. An item that
// gives no result queues no job. A bank-changing item gives four program
// slot results, plus eight pattern slot results when pattern ROM is
// present, one per cycle from the back end's output register while
// out_ready does not stall it; mirroring and IRQ jobs give one result. A
// QUEUE_DEPTH-entry job queue sits between the front end, which accepts one
// item per cycle while the queue has room, and the back end; the first
// result of an item passes through the queue, the back end's job register
// and its output register before it is on the outputs.
// Configuration is read directly and must only be written while idle.
// Depends on mmc3om_pkg, mmc3om_front, mmc3om_fifo and mmc3om_back.
`timescale 1ns / 1ps

module mmc3_outer_bank_mapper_unit
	import mmc3om_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            cmd,
	input  logic [15:0]           address,
	input  logic [7:0]            data,
	input  logic                  rendering_on,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  slot_valid,
	output logic                  slot_is_chr,
	output logic [2:0]            slot_number,
	output logic [7:0]            bank_number,
	output logic                  mirror_update,
	output logic                  mirror_horizontal,
	output logic                  irq_raise,
	output logic                  irq_clear,
	output logic                  last
);

	logic [8:0] prg_bank_count_q;
	logic       chr_rom_present_q;
	logic       quad_nt_q;

	logic       q_push, q_pop, q_full, q_not_empty;
	job_t       q_job, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_count_q  <= PRG_BANK_COUNT_RESET;
			chr_rom_present_q <= 1'b1;
			quad_nt_q         <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_PRG_BANK_COUNT:  prg_bank_count_q  <= cfg_wdata[8:0];
				CFG_CHR_ROM_PRESENT: chr_rom_present_q <= cfg_wdata[0];
				CFG_QUAD_NT:         quad_nt_q         <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	mmc3om_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.address      (address),
		.data         (data),
		.rendering_on (rendering_on),
		.quad_nt      (quad_nt_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (q_job)
	);

	mmc3om_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_job),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	mmc3om_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.prg_bank_count    (prg_bank_count_q),
		.chr_rom_present   (chr_rom_present_q),
		.q_head            (q_head),
		.q_not_empty       (q_not_empty),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.slot_valid        (slot_valid),
		.slot_is_chr       (slot_is_chr),
		.slot_number       (slot_number),
		.bank_number       (bank_number),
		.mirror_update     (mirror_update),
		.mirror_horizontal (mirror_horizontal),
		.irq_raise         (irq_raise),
		.irq_clear         (irq_clear),
		.last              (last)
	);

endmodule
